// ===== rtl/core/pvcd_pkg.sv =====
// ----------------------------------------------------------------------------
// pvcd_pkg - shared types and codes
// Result and configuration types, status codes and register indexes for the
// prefix-coded coefficient decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pvcd_pkg;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_FORMAT    = 3'd2;
    localparam logic [2:0] ST_DIMENSION = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;
    localparam logic [2:0] ST_PREFIX    = 3'd5;

    localparam logic [7:0] REG_MODULUS = 8'd0;
    localparam logic [7:0] REG_POLYS   = 8'd1;
    localparam logic [7:0] REG_DEGREE  = 8'd2;

    typedef struct packed {
        logic [23:0] value;
        logic [7:0]  poly_index;
        logic [15:0] coeff_index;
        logic [2:0]  status;
        logic        frame_done;
    } result_t;

    typedef struct packed {
        logic [31:0] modulus;
        logic [7:0]  expected_polys;
        logic [15:0] expected_degree;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/pvcd_front.sv =====
// ----------------------------------------------------------------------------
// pvcd_front - header check and prefix parser
// Takes one byte per cycle while the queue has room, checks the header,
// builds prefix codes, pushes one unreduced result per coefficient or error.
// ----------------------------------------------------------------------------
`default_nettype none

module pvcd_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  pvcd_pkg::cfg_t       cfg,
    input  wire                  byte_valid,
    input  wire [7:0]            byte_data,
    input  wire                  byte_last,
    output logic                 byte_ready,
    input  wire                  q_full,
    output logic                 push,
    output pvcd_pkg::result_t    push_data
);
    import pvcd_pkg::*;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_COEFF  = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  hcount_reg, hcount_next;
    logic [31:0] hstore_reg, hstore_next;
    logic [1:0]  pending_reg, pending_next;
    logic [23:0] acc_reg, acc_next;
    logic [7:0]  poly_reg, poly_next;
    logic [15:0] coeff_reg, coeff_next;

    logic        fire;
    logic        do_err, do_fin, restart, lip, last;
    logic [2:0]  err_code;
    logic [23:0] fin_val, acc_shift;
    logic [15:0] hdr_degree;

    assign byte_ready = !q_full;
    assign fire       = byte_valid && byte_ready;
    assign acc_shift  = {acc_reg[15:0], byte_data};
    assign hdr_degree = {hstore_reg[7:0], byte_data};
    assign lip  = ({1'b0, coeff_reg} + 17'd1) >= {1'b0, cfg.expected_degree};
    assign last = lip && (({1'b0, poly_reg} + 9'd1) >= {1'b0, cfg.expected_polys});

    always_comb
    begin
        phase_next   = phase_reg;
        hcount_next  = hcount_reg;
        hstore_next  = hstore_reg;
        pending_next = pending_reg;
        acc_next     = acc_reg;
        poly_next    = poly_reg;
        coeff_next   = coeff_reg;
        push         = 1'b0;
        push_data    = '0;
        do_err       = 1'b0;
        do_fin       = 1'b0;
        restart      = 1'b0;
        err_code     = ST_OK;
        fin_val      = '0;

        if (fire)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hcount_reg < 3'd4)
                    begin
                        if (byte_last)
                        begin
                            do_err   = 1'b1;
                            err_code = ST_SHORT;
                        end
                        else
                        begin
                            hstore_next = {hstore_reg[23:0], byte_data};
                            hcount_next = hcount_reg + 3'd1;
                        end
                    end
                    else if (hstore_reg[31:24] != 8'h01 || hstore_reg[23:16] != 8'h03)
                    begin
                        do_err   = 1'b1;
                        err_code = ST_FORMAT;
                    end
                    else if (hstore_reg[15:8] != cfg.expected_polys
                             || hdr_degree != cfg.expected_degree)
                    begin
                        do_err   = 1'b1;
                        err_code = ST_DIMENSION;
                    end
                    else if (cfg.expected_polys == 8'd0 || cfg.expected_degree == 16'd0)
                    begin
                        // empty frame: nothing to emit
                        if (byte_last)
                            restart = 1'b1;
                        else
                            phase_next = PH_SKIP;
                    end
                    else if (byte_last)
                    begin
                        do_err   = 1'b1;
                        err_code = ST_TRUNCATED;
                    end
                    else
                    begin
                        phase_next   = PH_COEFF;
                        pending_next = 2'd0;
                        acc_next     = '0;
                        poly_next    = '0;
                        coeff_next   = '0;
                    end
                end
                PH_COEFF:
                begin
                    if (pending_reg == 2'd0)
                    begin
                        priority if (byte_data == 8'h00)
                        begin
                            do_fin = 1'b1;
                        end
                        else if ((byte_data & 8'hC0) == 8'h80)
                        begin
                            do_fin  = 1'b1;
                            fin_val = {16'd0, byte_data & 8'h7F};
                        end
                        else if ((byte_data & 8'hE0) == 8'hC0)
                        begin
                            acc_next     = {16'd0, byte_data & 8'h3F};
                            pending_next = 2'd1;
                        end
                        else if ((byte_data & 8'hF0) == 8'hE0)
                        begin
                            acc_next     = {16'd0, byte_data & 8'h0F};
                            pending_next = 2'd2;
                        end
                        else if (byte_data == 8'hF0)
                        begin
                            acc_next     = '0;
                            pending_next = 2'd3;
                        end
                        else
                        begin
                            do_err   = 1'b1;
                            err_code = ST_PREFIX;
                        end
                        if (!do_fin && !do_err && byte_last)
                        begin
                            do_err   = 1'b1;
                            err_code = ST_TRUNCATED;
                        end
                    end
                    else
                    begin
                        acc_next     = acc_shift;
                        pending_next = pending_reg - 2'd1;
                        if (pending_reg == 2'd1)
                        begin
                            do_fin  = 1'b1;
                            fin_val = acc_shift;
                        end
                        else if (byte_last)
                        begin
                            do_err   = 1'b1;
                            err_code = ST_TRUNCATED;
                        end
                    end
                end
                default:
                begin
                    if (byte_last)
                        restart = 1'b1;
                end
            endcase

            if (do_fin)
            begin
                if (!last && byte_last)
                begin
                    // end of buffer before the last coefficient
                    do_err   = 1'b1;
                    err_code = ST_TRUNCATED;
                end
                else
                begin
                    push                 = 1'b1;
                    push_data.value       = fin_val;
                    push_data.poly_index  = poly_reg;
                    push_data.coeff_index = coeff_reg;
                    push_data.status      = ST_OK;
                    push_data.frame_done  = last;
                    if (last)
                    begin
                        if (byte_last)
                            restart = 1'b1;
                        else
                            phase_next = PH_SKIP;
                    end
                    else if (lip)
                    begin
                        coeff_next = '0;
                        poly_next  = poly_reg + 8'd1;
                    end
                    else
                    begin
                        coeff_next = coeff_reg + 16'd1;
                    end
                end
            end

            if (do_err)
            begin
                push                 = 1'b1;
                push_data            = '0;
                push_data.status     = err_code;
                push_data.frame_done = 1'b1;
                if (byte_last)
                    restart = 1'b1;
                else
                    phase_next = PH_SKIP;
            end

            if (restart)
            begin
                phase_next   = PH_HEADER;
                hcount_next  = '0;
                hstore_next  = '0;
                pending_next = '0;
                acc_next     = '0;
                poly_next    = '0;
                coeff_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hcount_reg  <= '0;
            hstore_reg  <= '0;
            pending_reg <= '0;
            acc_reg     <= '0;
            poly_reg    <= '0;
            coeff_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hcount_reg  <= hcount_next;
            hstore_reg  <= hstore_next;
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
            poly_reg    <= poly_next;
            coeff_reg   <= coeff_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pvcd_queue.sv =====
// ----------------------------------------------------------------------------
// pvcd_queue - result queue
// Small FIFO of unreduced results between parser and reduction unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pvcd_queue #(
    parameter int DEPTH = 4
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  pvcd_pkg::result_t    push_data,
    input  wire                  pop,
    output logic                 full,
    output logic                 empty,
    output pvcd_pkg::result_t    head
);
    import pvcd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t         mem [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop && !empty)
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            count_reg <= count_reg + CW'(push && !full) - CW'(pop && !empty);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !pop) |=> full)
        else $error("queue left full state without a pop");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !push) |=> empty)
        else $error("queue filled without a push");

endmodule

`default_nettype wire

// ===== rtl/core/pvcd_back.sv =====
// ----------------------------------------------------------------------------
// pvcd_back - modulus reduction and output register
// Restoring remainder, one bit per cycle, then holds the result for the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module pvcd_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire [31:0]           modulus,
    input  wire                  q_empty,
    input  pvcd_pkg::result_t    q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire                  out_ready,
    output pvcd_pkg::result_t    out_data
);
    import pvcd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]  state_reg;
    logic [31:0] rem_reg;
    logic [23:0] val_reg;
    logic [4:0]  cnt_reg;
    result_t     hold_reg;

    logic [32:0] trial;
    logic        ge;

    assign trial = {rem_reg, val_reg[23]};
    assign ge    = trial >= {1'b0, modulus};
    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    assign out_valid = (state_reg == S_OUT);
    always_comb
    begin
        out_data       = hold_reg;
        out_data.value = rem_reg[23:0];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            hold_reg <= q_head;
            val_reg  <= q_head.value;
            // modulus zero means no reduction
            rem_reg  <= (modulus == 32'd0) ? {8'd0, q_head.value} : '0;
        end
        else if (state_reg == S_DIV)
        begin
            rem_reg <= ge ? 32'(trial - {1'b0, modulus}) : trial[31:0];
            val_reg <= {val_reg[22:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (modulus == 32'd0) ? S_OUT : S_DIV;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd23)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == 5'd23) |=> state_reg == S_OUT)
        else $error("reduction did not finish after 24 steps");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE)
        else $error("pop while reduction busy");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg <= 5'd23)
        else $error("step counter out of range");

endmodule

`default_nettype wire

// ===== rtl/core/prefix_varint_coeff_decoder.sv =====
// ----------------------------------------------------------------------------
// prefix_varint_coeff_decoder - framed prefix-code coefficient decoder
// Header check, prefix decode and modulus reduction of packed coefficients.
// ----------------------------------------------------------------------------
// The parser takes one frame byte per cycle (s_tlast marks the last byte of
// the buffer) as long as the result queue has room; every byte waits while
// the queue is full. The back end reduces each result in a bit-serial
// remainder unit (skipped for modulus 0) and holds it until it is taken.
// Headers and multi-byte codes overlap with that work via a QUEUE_DEPTH-entry
// queue, so the sustained rate is one byte per cycle while results are
// sparse; a dense stream of short codes waits on the back end, which takes
// a new result only once the last has left. Errors come out as one item
// with frame_done (tlast) set and a non-zero status; the consumer drops the
// earlier results of that frame. The user writes configuration through cfg_*
// only while idle; cfg_* is always ready and the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_varint_coeff_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire         clk,
    input  wire         rst_n,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [7:0]   s_tdata,   // [7:0] data_byte
    input  wire         s_tlast,   // end_of_data
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // [23:0] coefficient, [31:24] poly_index,
                                   // [47:32] coeff_index
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast,   // frame_done
    // register writes
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [7:0]   cfg_index,
    input  wire [31:0]  cfg_data
);
    import pvcd_pkg::*;

    cfg_t    cfg_reg;
    logic    q_full, q_empty, q_push, q_pop;
    result_t push_data, q_head, out_data;

    assign cfg_ready = 1'b1;

    // register file: writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modulus         <= 32'd3329;
            cfg_reg.expected_polys  <= 8'd2;
            cfg_reg.expected_degree <= 16'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_MODULUS)
                cfg_reg.modulus <= cfg_data;
            else if (cfg_index == REG_POLYS)
                cfg_reg.expected_polys <= cfg_data[7:0];
            else if (cfg_index == REG_DEGREE)
                cfg_reg.expected_degree <= cfg_data[15:0];
        end
    end

    pvcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .byte_valid (s_tvalid),
        .byte_data  (s_tdata),
        .byte_last  (s_tlast),
        .byte_ready (s_tready),
        .q_full     (q_full),
        .push       (q_push),
        .push_data  (push_data)
    );

    pvcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    pvcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .modulus   (cfg_reg.modulus),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.coeff_index, out_data.poly_index, out_data.value};
    assign m_tuser = out_data.status;
    assign m_tlast = out_data.frame_done;

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !s_tready)
        else $error("byte taken with queue full");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> m_tlast)
        else $error("error item without frame_done");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> m_tdata == 48'd0)
        else $error("error item with non-zero payload");

endmodule

`default_nettype wire
